// ===== rtl/sphere_sphere_contact_defines.svh =====
// Assertion macros for the sphere contact checker
`ifndef SPHERE_SPHERE_CONTACT_DEFINES_SVH
`define SPHERE_SPHERE_CONTACT_DEFINES_SVH

// Check a property on every rising edge outside reset
`define SSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition leads to a consequence in the next cycle
`define SSC_ASSERT_NEXT(label, pre, post, msg) \
  `SSC_ASSERT(label, (pre) |=> (post), msg)

`endif

// ===== rtl/ssc_pkg.sv =====
// Shared widths, depths and sideband types of the sphere contact pipeline
`timescale 1ns / 1ps
package ssc_pkg;

  localparam int COORD_W      = 32;
  localparam int RAD_W        = 31;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int MAG_W        = COORD_W;
  localparam int SQ_W         = 2 * MAG_W;
  localparam int SUM_W        = SQ_W + 2;
  localparam int ROOT_W       = SQ_W / 2;
  localparam int PROD_W       = MAG_W + RAD_W;
  localparam int NUM_W        = 2 * ROOT_W;
  localparam int QUO_W        = ROOT_W;
  localparam int AXES         = 3;
  localparam int SQ_STAGES    = ROOT_W;
  localparam int DIV_STAGES   = QUO_W;
  localparam int FRONT_STAGES = 4;
  localparam int IN_DATA_W    = 256;
  localparam int OUT_DATA_W   = 6 * COORD_W;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [RAD_W-1:0] rad_t;
  typedef logic [MAG_W-1:0] mag_t;

  // Carried alongside the square root
  typedef struct packed {
    mag_t   [AXES-1:0] mag;
    logic   [AXES-1:0] neg;
    coord_t [AXES-1:0] ca;
    coord_t [AXES-1:0] cb;
    rad_t              ra;
    rad_t              rb;
    logic              hit;
  } sq_side_t;

  // Carried alongside the dividers
  typedef struct packed {
    logic   [AXES-1:0] neg;
    coord_t [AXES-1:0] ca;
    coord_t [AXES-1:0] cb;
    logic              hit;
    logic              len_zero;
  } dv_side_t;

endpackage

// ===== rtl/sphere_sphere_contact.sv =====
// Pipeline: 4 front stages, 32 square-root stages, 2 product stages,
// 32 divider stages and 1 output stage between request accept and result valid.
// Throughput: one request per cycle; the whole pipeline holds while a result
// waits at the output and out_tready is low.
// Reset: synchronous active-low rst_n clears all stage valid bits; data
// registers are not reset.
`timescale 1ns / 1ps
module sphere_sphere_contact (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // center_a_x, center_a_y, center_a_z, radius_a, center_b_x, center_b_y,
  // center_b_z, radius_b, two zero pad bits
  input  logic [ssc_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // contact_a_x, contact_a_y, contact_a_z, contact_b_x, contact_b_y, contact_b_z
  output logic [ssc_pkg::OUT_DATA_W-1:0]   out_tdata,
  // hit
  output logic                             out_tuser
);
  import ssc_pkg::*;

  localparam int LAT = FRONT_STAGES + SQ_STAGES + 2 + DIV_STAGES + 1;

  function automatic coord_t sat_coord(input logic signed [COORD_W+2:0] v);
    if (v[COORD_W+2:COORD_W-1] == {4{v[COORD_W+2]}}) begin
      return v[COORD_W-1:0];
    end
    return v[COORD_W+2] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
  endfunction

  logic           en;
  logic [LAT-1:0] vld_r;

  // Hold every stage while the output request is stalled
  assign en         = !vld_r[LAT-1] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // Unpack the request
  coord_t in_ca [AXES];
  coord_t in_cb [AXES];
  rad_t   in_ra, in_rb;

  assign in_ca[0] = in_tdata[31:0];
  assign in_ca[1] = in_tdata[63:32];
  assign in_ca[2] = in_tdata[95:64];
  assign in_ra    = in_tdata[126:96];
  assign in_cb[0] = in_tdata[158:127];
  assign in_cb[1] = in_tdata[190:159];
  assign in_cb[2] = in_tdata[222:191];
  assign in_rb    = in_tdata[253:223];

  // Stage 1: difference vector, magnitudes, radius sum
  logic signed [DIFF_W-1:0] d_c [AXES];
  sq_side_t                 s1_side_r;
  logic [RAD_W:0]           s1_rsum_r;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      d_c[i] = DIFF_W'(in_cb[i]) - DIFF_W'(in_ca[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < AXES; i++) begin
        s1_side_r.neg[i] <= d_c[i][DIFF_W-1];
        s1_side_r.mag[i] <= d_c[i][DIFF_W-1] ? MAG_W'(-d_c[i]) : MAG_W'(d_c[i]);
        s1_side_r.ca[i]  <= in_ca[i];
        s1_side_r.cb[i]  <= in_cb[i];
      end
      s1_side_r.ra  <= in_ra;
      s1_side_r.rb  <= in_rb;
      s1_side_r.hit <= 1'b0;
      s1_rsum_r     <= {1'b0, in_ra} + {1'b0, in_rb};
    end
  end

  // Stage 2: squares
  sq_side_t       s2_side_r;
  logic [SQ_W-1:0] s2_sq_r [AXES];
  logic [SQ_W-1:0] s2_rsq_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < AXES; i++) begin
        s2_sq_r[i] <= s1_side_r.mag[i] * s1_side_r.mag[i];
      end
      s2_rsq_r  <= s1_rsum_r * s1_rsum_r;
      s2_side_r <= s1_side_r;
    end
  end

  // Stage 3: partial sum of squares
  sq_side_t         s3_side_r;
  logic [SUM_W-1:0] s3_p01_r;
  logic [SQ_W-1:0]  s3_sq2_r;
  logic [SQ_W-1:0]  s3_rsq_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_p01_r  <= SUM_W'(s2_sq_r[0]) + SUM_W'(s2_sq_r[1]);
      s3_sq2_r  <= s2_sq_r[2];
      s3_rsq_r  <= s2_rsq_r;
      s3_side_r <= s2_side_r;
    end
  end

  // Stage 4: full squared length and hit decision
  logic [SUM_W-1:0] s4_sum_c;
  logic             s4_hit_c;
  sq_side_t         s4_side_c;
  sq_side_t         s4_side_r;
  logic [SQ_W-1:0]  s4_x_r;

  assign s4_sum_c = s3_p01_r + SUM_W'(s3_sq2_r);
  assign s4_hit_c = s4_sum_c <= SUM_W'(s3_rsq_r);

  // Merge the hit decision into the sideband
  always_comb begin
    s4_side_c     = s3_side_r;
    s4_side_c.hit = s4_hit_c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_side_r <= s4_side_c;
      s4_x_r    <= s4_hit_c ? s4_sum_c[SQ_W-1:0] : '0;
    end
  end

  // Length by square root, sideband delayed to match
  logic [ROOT_W-1:0] len;
  sq_side_t          sq_side_r [SQ_STAGES];

  ssc_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .x    (s4_x_r),
    .root (len)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sq_side_r[0] <= s4_side_r;
      for (int k = 1; k < SQ_STAGES; k++) begin
        sq_side_r[k] <= sq_side_r[k-1];
      end
    end
  end

  // Product stage: magnitude times radius for each axis and sphere
  sq_side_t           sq_last;
  logic [PROD_W-1:0]  m_prod_r [2*AXES];
  logic [ROOT_W-1:0]  m_len_r;
  dv_side_t           m_side_r;

  assign sq_last = sq_side_r[SQ_STAGES-1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < AXES; i++) begin
        m_prod_r[i]      <= sq_last.mag[i] * sq_last.ra;
        m_prod_r[AXES+i] <= sq_last.mag[i] * sq_last.rb;
      end
      m_len_r           <= len;
      m_side_r.neg      <= sq_last.neg;
      m_side_r.ca       <= sq_last.ca;
      m_side_r.cb       <= sq_last.cb;
      m_side_r.hit      <= sq_last.hit;
      m_side_r.len_zero <= (len == '0);
    end
  end

  // Rounding stage: add half the length
  logic [NUM_W-1:0]  r_num_r [2*AXES];
  logic [ROOT_W-1:0] r_len_r;
  dv_side_t          r_side_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 2 * AXES; j++) begin
        r_num_r[j] <= NUM_W'(m_prod_r[j]) + NUM_W'(m_len_r >> 1);
      end
      r_len_r  <= m_len_r;
      r_side_r <= m_side_r;
    end
  end

  // Six offset dividers, sideband delayed to match
  logic [QUO_W-1:0] quo [2*AXES];
  dv_side_t         dv_side_r [DIV_STAGES];

  for (genvar j = 0; j < 2 * AXES; j++) begin : g_div
    ssc_div u_div (
      .clk (clk),
      .en  (en),
      .num (r_num_r[j]),
      .den (r_len_r),
      .quo (quo[j])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_side_r[0] <= r_side_r;
      for (int k = 1; k < DIV_STAGES; k++) begin
        dv_side_r[k] <= dv_side_r[k-1];
      end
    end
  end

  // Output stage: apply the signed offsets, saturate, zero on a miss
  dv_side_t                    dv_last;
  logic signed [COORD_W+1:0]   off_c [2*AXES];
  logic signed [COORD_W+2:0]   pos_c [2*AXES];
  coord_t                      res_c [2*AXES];

  assign dv_last = dv_side_r[DIV_STAGES-1];

  always_comb begin
    for (int j = 0; j < 2 * AXES; j++) begin
      off_c[j] = {2'b00, quo[j]};
      if (dv_last.len_zero) begin
        off_c[j] = '0;
      end else if (dv_last.neg[j % AXES]) begin
        off_c[j] = -off_c[j];
      end
    end
    for (int i = 0; i < AXES; i++) begin
      pos_c[i]      = (COORD_W+3)'($signed(dv_last.ca[i])) + (COORD_W+3)'(off_c[i]);
      pos_c[AXES+i] = (COORD_W+3)'($signed(dv_last.cb[i])) - (COORD_W+3)'(off_c[AXES+i]);
    end
    for (int j = 0; j < 2 * AXES; j++) begin
      res_c[j] = dv_last.hit ? sat_coord(pos_c[j]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 2 * AXES; j++) begin
        out_tdata[j*COORD_W +: COORD_W] <= res_c[j];
      end
      out_tuser <= dv_last.hit;
    end
  end

endmodule

// ===== rtl/ssc_sqrt.sv =====
// Pipelined integer square root, one root bit per register stage
`timescale 1ns / 1ps
module ssc_sqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [ssc_pkg::SQ_W-1:0]    x,
  output logic [ssc_pkg::ROOT_W-1:0]  root
);
  import ssc_pkg::*;

  localparam int REM_W = ROOT_W + 2;

  logic [REM_W-1:0]  rem_r   [SQ_STAGES];
  logic [ROOT_W-1:0] root_r  [SQ_STAGES];
  logic [SQ_W-1:0]   xs_r    [SQ_STAGES];
  logic [REM_W-1:0]  rem_nxt [SQ_STAGES];
  logic [ROOT_W-1:0] root_nxt[SQ_STAGES];
  logic [SQ_W-1:0]   xs_nxt  [SQ_STAGES];
  logic [REM_W-1:0]  rem_in  [SQ_STAGES];
  logic [ROOT_W-1:0] root_in [SQ_STAGES];
  logic [SQ_W-1:0]   xs_in   [SQ_STAGES];
  logic [REM_W-1:0]  rem_sh  [SQ_STAGES];
  logic [REM_W-1:0]  trial   [SQ_STAGES];
  logic              ge      [SQ_STAGES];

  // Bring down two radicand bits and try the next root bit
  always_comb begin
    for (int k = 0; k < SQ_STAGES; k++) begin
      if (k == 0) begin
        rem_in[k]  = '0;
        root_in[k] = '0;
        xs_in[k]   = x;
      end else begin
        rem_in[k]  = rem_r[k-1];
        root_in[k] = root_r[k-1];
        xs_in[k]   = xs_r[k-1];
      end
      rem_sh[k]   = {rem_in[k][ROOT_W-1:0], xs_in[k][SQ_W-1 -: 2]};
      trial[k]    = {root_in[k], 2'b01};
      ge[k]       = rem_sh[k] >= trial[k];
      rem_nxt[k]  = ge[k] ? rem_sh[k] - trial[k] : rem_sh[k];
      root_nxt[k] = {root_in[k][ROOT_W-2:0], ge[k]};
      xs_nxt[k]   = {xs_in[k][SQ_W-3:0], 2'b00};
    end
  end

  // Advance all stages together
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQ_STAGES; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        xs_r[k]   <= xs_nxt[k];
      end
    end
  end

  assign root = root_r[SQ_STAGES-1];

endmodule

// ===== rtl/ssc_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage
`timescale 1ns / 1ps
module ssc_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [ssc_pkg::NUM_W-1:0]   num,
  input  logic [ssc_pkg::ROOT_W-1:0]  den,
  output logic [ssc_pkg::QUO_W-1:0]   quo
);
  import ssc_pkg::*;

  localparam int LOW_W = NUM_W - ROOT_W;

  logic [ROOT_W-1:0] rem_r   [DIV_STAGES];
  logic [LOW_W-1:0]  low_r   [DIV_STAGES];
  logic [ROOT_W-1:0] den_r   [DIV_STAGES];
  logic [QUO_W-1:0]  quo_r   [DIV_STAGES];
  logic [ROOT_W-1:0] rem_in  [DIV_STAGES];
  logic [LOW_W-1:0]  low_in  [DIV_STAGES];
  logic [ROOT_W-1:0] den_in  [DIV_STAGES];
  logic [QUO_W-1:0]  quo_in  [DIV_STAGES];
  logic [ROOT_W:0]   part    [DIV_STAGES];
  logic [ROOT_W:0]   diff    [DIV_STAGES];
  logic              ge      [DIV_STAGES];

  // Shift in one numerator bit and subtract where the divisor fits
  // (the upper numerator half is below the divisor, so the quotient fits)
  always_comb begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (k == 0) begin
        rem_in[k] = num[NUM_W-1:LOW_W];
        low_in[k] = num[LOW_W-1:0];
        den_in[k] = den;
        quo_in[k] = '0;
      end else begin
        rem_in[k] = rem_r[k-1];
        low_in[k] = low_r[k-1];
        den_in[k] = den_r[k-1];
        quo_in[k] = quo_r[k-1];
      end
      part[k] = {rem_in[k], low_in[k][LOW_W-1]};
      ge[k]   = part[k] >= {1'b0, den_in[k]};
      diff[k] = part[k] - {1'b0, den_in[k]};
    end
  end

  // Advance all stages together
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        rem_r[k] <= ge[k] ? diff[k][ROOT_W-1:0] : part[k][ROOT_W-1:0];
        low_r[k] <= {low_in[k][LOW_W-2:0], 1'b0};
        den_r[k] <= den_in[k];
        quo_r[k] <= {quo_in[k][QUO_W-2:0], ge[k]};
      end
    end
  end

  assign quo = quo_r[DIV_STAGES-1];

endmodule

// ===== rtl/ssc_checker.sv =====
// Port-level checker for the sphere contact pipeline, bound to the top level
`timescale 1ns / 1ps
`include "sphere_sphere_contact_defines.svh"
module ssc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ssc_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic                            out_tuser
);
  import ssc_pkg::*;

  // Hold a stalled result request
  `SSC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "stalled result dropped")

  // Drop no contact data on a miss: all coordinates read zero
  `SSC_ASSERT(a_miss_zero, (out_tvalid && !out_tuser) |-> (out_tdata == '0), "miss with data")

  // Accept requests whenever the output stage is empty
  `SSC_ASSERT(a_ready_empty, !out_tvalid |-> in_tready, "not ready with empty output")

endmodule

bind sphere_sphere_contact ssc_checker u_ssc_checker (.*);
